// ===== rtl/core/bounded_array_list_defines.svh =====
// Assertion macros shared by the bounded array list RTL.
`ifndef BOUNDED_ARRAY_LIST_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_DEFINES_SVH

// Check that expr holds in the same cycle as cond.
`define BAL_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("bounded_array_list assertion failed");

// Check that expr holds in the cycle after cond.
`define BAL_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("bounded_array_list assertion failed");

`endif

// ===== rtl/core/bal_pkg.sv =====
// Shared types and codes for the bounded array list.
package bal_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 4;
   localparam int LIVE_W   = 5;

   localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DUMP    = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd3;

   typedef enum logic [2:0] {
      OP_APPEND,
      OP_INSERT,
      OP_DELETE,
      OP_REVERSE,
      OP_DUMP,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } cmd_type;

endpackage

// ===== rtl/core/bounded_array_list.sv =====
// Top level of the bounded array list: front end, command queue and back end.
// A bounded list of up to CAPACITY signed 32-bit entries supporting append, insert, delete,
// reverse and dump. Append, insert, delete and reverse each yield one result transaction;
// a dump yields one result per live entry (one for an empty list) at one per cycle while
// the result side does not stall, and it holds the back end until its last result. Results
// leave through the single registered result stage of the back end. A two-entry
// command queue in front keeps taking request transactions while it has room, also
// while the back end works or the result side stalls.
`include "bounded_array_list_defines.svh"

module bounded_array_list #(
   parameter int CAPACITY = bal_pkg::CAPACITY_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [bal_pkg::KIND_W-1:0]           req_kind,
   input  logic signed [bal_pkg::VALUE_W-1:0]   req_value,
   input  logic [bal_pkg::POS_W-1:0]            req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [bal_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [bal_pkg::VALUE_W-1:0]   rsp_element,
   output logic [bal_pkg::INDEX_W-1:0]          rsp_element_index,
   output logic [bal_pkg::LIVE_W-1:0]           rsp_live_count,
   output logic                                 rsp_last
);

   logic             q_valid;
   logic             q_pop;
   bal_pkg::cmd_type q_cmd;
   logic             rsp_error;
   logic             rsp_indexed;

   bal_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .req_position (req_position),
      .q_valid      (q_valid),
      .q_cmd        (q_cmd),
      .q_pop        (q_pop)
   );

   bal_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_cmd             (q_cmd),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_element       (rsp_element),
      .rsp_element_index (rsp_element_index),
      .rsp_live_count    (rsp_live_count),
      .rsp_last          (rsp_last)
   );

   assign rsp_error   = rsp_valid && (rsp_status != bal_pkg::STATUS_OK);
   assign rsp_indexed = rsp_valid && (rsp_element_index != '0);

   `BAL_ASSERT_SAME(a_pop_needs_cmd, clock, reset, q_pop, q_valid)
   `BAL_ASSERT_NEXT(a_push_shows_cmd, clock, reset, req_valid && req_ready && !q_valid, q_valid)
   `BAL_ASSERT_SAME(a_error_is_last, clock, reset, rsp_error, rsp_last)
   `BAL_ASSERT_SAME(a_index_only_ok, clock, reset, rsp_indexed, rsp_status == bal_pkg::STATUS_OK)

endmodule

// ===== rtl/core/bal_front.sv =====
// Front end: accepts request transactions, decodes them and queues commands.
module bal_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bal_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [bal_pkg::VALUE_W-1:0]  req_value,
   input  logic [bal_pkg::POS_W-1:0]           req_position,
   output logic                                q_valid,
   output bal_pkg::cmd_type                    q_cmd,
   input  logic                                q_pop
);

   bal_pkg::cmd_type queue_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   bal_pkg::cmd_type decoded;
   logic             push;

   always_comb begin
      decoded.value    = req_value;
      decoded.position = req_position;
      case (req_kind)
         bal_pkg::KIND_APPEND:  decoded.op = bal_pkg::OP_APPEND;
         bal_pkg::KIND_INSERT:  decoded.op = bal_pkg::OP_INSERT;
         bal_pkg::KIND_DELETE:  decoded.op = bal_pkg::OP_DELETE;
         bal_pkg::KIND_REVERSE: decoded.op = bal_pkg::OP_REVERSE;
         bal_pkg::KIND_DUMP:    decoded.op = bal_pkg::OP_DUMP;
         default:               decoded.op = bal_pkg::OP_NOP;
      endcase
   end

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_cmd     = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== rtl/core/bal_back.sv =====
// Back end: holds the list, executes commands and drives result transactions.
module bal_back #(
   parameter int CAPACITY = bal_pkg::CAPACITY_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  bal_pkg::cmd_type                     q_cmd,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [bal_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [bal_pkg::VALUE_W-1:0]   rsp_element,
   output logic [bal_pkg::INDEX_W-1:0]          rsp_element_index,
   output logic [bal_pkg::LIVE_W-1:0]           rsp_live_count,
   output logic                                 rsp_last
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int XW = (CW > bal_pkg::POS_W) ? CW : bal_pkg::POS_W;

   typedef enum logic {S_IDLE, S_DUMP} state_type;

   state_type                         state_ff, state_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [IW-1:0]                     idx_ff, idx_in;
   logic signed [bal_pkg::VALUE_W-1:0] store_ff [CAPACITY];
   logic signed [bal_pkg::VALUE_W-1:0] store_in [CAPACITY];

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bal_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic signed [bal_pkg::VALUE_W-1:0] element_ff, element_in;
   logic [bal_pkg::INDEX_W-1:0]       index_ff, index_in;
   logic [bal_pkg::LIVE_W-1:0]        live_ff, live_in;
   logic                              last_ff, last_in;

   logic          out_free;
   logic          start;
   logic          full;
   logic [XW-1:0] cnt_x;
   logic [XW-1:0] pos_x;
   logic [XW-1:0] ins_pos;
   logic          ins_en;
   logic          del_en;
   logic          rev_en;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign start    = (state_ff == S_IDLE) && q_valid && out_free;
   assign q_pop    = start;
   assign full     = (count_ff == CW'(CAPACITY));
   assign cnt_x    = XW'(count_ff);
   assign pos_x    = XW'(q_cmd.position);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      element_in   = element_ff;
      index_in     = index_ff;
      live_in      = live_ff;
      last_in      = last_ff;
      ins_en       = 1'b0;
      del_en       = 1'b0;
      rev_en       = 1'b0;
      ins_pos      = pos_x;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_valid_in = 1'b1;
               status_in    = bal_pkg::STATUS_OK;
               element_in   = '0;
               index_in     = '0;
               last_in      = 1'b1;
               case (q_cmd.op)
                  bal_pkg::OP_APPEND: begin
                     if (full) begin
                        status_in = bal_pkg::STATUS_FULL;
                     end else begin
                        ins_en   = 1'b1;
                        ins_pos  = cnt_x;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  bal_pkg::OP_INSERT: begin
                     if (full) begin
                        status_in = bal_pkg::STATUS_FULL;
                     end else if (pos_x > cnt_x) begin
                        status_in = bal_pkg::STATUS_BADPOS;
                     end else begin
                        ins_en   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  bal_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = bal_pkg::STATUS_EMPTY;
                     end else if (pos_x >= cnt_x) begin
                        status_in = bal_pkg::STATUS_BADPOS;
                     end else begin
                        del_en   = 1'b1;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  bal_pkg::OP_REVERSE: begin
                     rev_en = 1'b1;
                  end
                  bal_pkg::OP_DUMP: begin
                     if (count_ff == '0) begin
                        status_in = bal_pkg::STATUS_EMPTY;
                     end else begin
                        element_in = store_ff[0];
                        if (count_ff != CW'(1)) begin
                           last_in  = 1'b0;
                           state_in = S_DUMP;
                           idx_in   = IW'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               live_in = bal_pkg::LIVE_W'(count_in);
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = bal_pkg::STATUS_OK;
               element_in   = store_ff[idx_ff];
               index_in     = bal_pkg::INDEX_W'(idx_ff);
               live_in      = bal_pkg::LIVE_W'(count_ff);
               last_in      = (XW'(idx_ff) + XW'(1) == cnt_x);
               idx_in       = idx_ff + IW'(1);
               if (last_in) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         store_in[i] = store_ff[i];
         if (ins_en) begin
            if (XW'(i) == ins_pos) begin
               store_in[i] = q_cmd.value;
            end else if (XW'(i) > ins_pos) begin
               store_in[i] = store_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (del_en) begin
            if (XW'(i) >= pos_x) begin
               store_in[i] = store_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end else if (rev_en) begin
            if (XW'(i) < cnt_x) begin
               store_in[i] = store_ff[IW'(cnt_x - XW'(1) - XW'(i))];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   always_ff @(posedge clock) begin
      state_ff     <= state_in;
      count_ff     <= count_in;
      idx_ff       <= idx_in;
      rsp_valid_ff <= rsp_valid_in;
      status_ff    <= status_in;
      element_ff   <= element_in;
      index_ff     <= index_in;
      live_ff      <= live_in;
      last_ff      <= last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_element       = element_ff;
   assign rsp_element_index = index_ff;
   assign rsp_live_count    = live_ff;
   assign rsp_last          = last_ff;

endmodule
